[src/odc_pkg.sv]
// shared constants and count arithmetic for the odd divisor counter
package odc_pkg;

   localparam int VALUE_WIDTH = 47;
   localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int EXP_WIDTH   = $clog2(VALUE_WIDTH + 1);
   localparam int FAC_WIDTH   = EXP_WIDTH + 1;
   localparam int COUNT_WIDTH = 15;
   localparam int PROD_WIDTH  = COUNT_WIDTH + FAC_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [DIV_WIDTH-1:0]   divisor_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [FAC_WIDTH-1:0]   factor_type;

   function automatic count_type sat_mul(input count_type a, input factor_type b);
      logic [PROD_WIDTH-1:0] p;
      p = PROD_WIDTH'(a) * PROD_WIDTH'(b);
      if (p > PROD_WIDTH'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return p[COUNT_WIDTH-1:0];
   endfunction

endpackage

[src/odd_divisor_counter_unit.sv]
// odd divisor counter: trial division over one shared restoring divider
// sequence: the trailing zeros are stripped first, then one division per
//   odd trial divisor up to the square root of the odd part plus one per factor found;
//   a zero value is flagged as bad input without any division
// throughput: one transaction at a time; the bit-serial divider sets the pace
// reset: synchronous, active high; clears the sequencer and the result valid
module odd_divisor_counter_unit
   import odc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COUNT_WIDTH-1:0] rsp_ways,
   output logic                   rsp_bad_input
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STRIP = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(VALUE_WIDTH - 1);

   logic [2:0]            state_ff, state_in;
   value_type             rem_ff, rem_in;
   divisor_type           div_ff, div_in;
   count_type             cnt_ff, cnt_in;
   logic [EXP_WIDTH-1:0]  exp_ff, exp_in;
   divisor_type           acc_ff, acc_in;
   value_type             quo_ff, quo_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   count_type             rsp_ways_ff, rsp_ways_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic [DIV_WIDTH:0]    trial;
   logic                  fits;
   logic                  div_le_quo;
   logic                  rem_done;
   count_type             final_cnt;
   logic                  out_free;

   assign trial      = {acc_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits       = trial >= {1'b0, div_ff};
   assign div_le_quo = VALUE_WIDTH'(div_ff) <= quo_ff;
   assign rem_done   = acc_ff == '0;
   assign final_cnt  = (rem_ff > VALUE_WIDTH'(1)) ? sat_mul(cnt_ff, FAC_WIDTH'(2)) : cnt_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ways_in  = rsp_ways_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in = req_value;
               cnt_in = COUNT_WIDTH'(1);
               exp_in = '0;
               div_in = DIV_WIDTH'(3);
               if (req_value == '0) begin
                  bad_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (rem_ff[0]) begin
               acc_in   = '0;
               quo_in   = rem_ff;
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               rem_in = rem_ff >> 1;
            end
         end
         ST_DIV: begin
            acc_in  = fits ? DIV_WIDTH'(trial - {1'b0, div_ff}) : trial[DIV_WIDTH-1:0];
            quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            acc_in  = '0;
            step_in = '0;
            if (rem_done && (exp_ff != '0 || div_le_quo)) begin
               rem_in   = quo_ff;
               exp_in   = exp_ff + EXP_WIDTH'(1);
               state_in = ST_DIV;
            end else if (exp_ff != '0) begin
               cnt_in   = sat_mul(cnt_ff, FAC_WIDTH'(exp_ff) + FAC_WIDTH'(1));
               exp_in   = '0;
               div_in   = div_ff + DIV_WIDTH'(2);
               quo_in   = rem_ff;
               state_in = ST_DIV;
            end else if (div_le_quo) begin
               div_in   = div_ff + DIV_WIDTH'(2);
               quo_in   = rem_ff;
               state_in = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = bad_ff;
               rsp_ways_in  = bad_ff ? '0 : final_cnt - COUNT_WIDTH'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      bad_ff      <= bad_in;
      rsp_ways_ff <= rsp_ways_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ways      = rsp_ways_ff;
   assign rsp_bad_input = rsp_bad_ff;

endmodule
